FILE: sv/ikh_pkg.sv
package ikh_pkg;

  localparam int SIZE_W   = 4;
  localparam int PLIM_W   = 15;
  localparam int COUNT_W  = 5;
  localparam int SEAT_W   = 3;
  localparam int ROUND_W  = 2;
  localparam int BUCKET_W = 8;
  localparam int SMALL_W  = SEAT_W + ROUND_W + BUCKET_W;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [KEY_W-1:0]   GOLDEN           = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [COUNT_W-1:0] MAX_ACTION_COUNT = 5'd20;
  localparam logic [SIZE_W-1:0]  MIN_SIZE_LOG2    = 4'd4;
  localparam logic [SIZE_W-1:0]  RST_SIZE_LOG2    = 4'd14;
  localparam logic [PLIM_W-1:0]  RST_PROBE_LIMIT  = 15'd1000;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_TABLE_SIZE  = 1'b0;
  localparam logic REG_PROBE_LIMIT = 1'b1;

  typedef struct packed {
    logic clr;
    logic load;
    logic hash;
    logic start;
    logic probe;
    logic commit;
  } ikh_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hash_done;
    logic probe_done;
  } ikh_stat_t;

  function automatic logic [KEY_W-1:0] ikh_mix(input logic [KEY_W-1:0] a,
                                               input logic [KEY_W-1:0] b);
    return a ^ (b + GOLDEN + (a << 6) + (a >> 2));
  endfunction

endpackage

FILE: sv/ikh_if.sv
interface ikh_query_if;
  import ikh_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [SEAT_W-1:0]   player_seat;
  logic [ROUND_W-1:0]  round_number;
  logic [BUCKET_W-1:0] strength_bucket;
  logic [KEY_W-1:0]    board_key;
  logic [KEY_W-1:0]    history_key;
  logic [COUNT_W-1:0]  action_count;

  modport source (output valid, mode, player_seat, round_number, strength_bucket,
                  board_key, history_key, action_count, input ready);
  modport sink   (input valid, mode, player_seat, round_number, strength_bucket,
                  board_key, history_key, action_count, output ready);
endinterface

interface ikh_result_if #(parameter int SLOT_W = 14);
  import ikh_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [COUNT_W-1:0]  stored_count;

  modport source (output valid, status, slot_index, stored_count, input ready);
  modport sink   (input valid, status, slot_index, stored_count, output ready);
endinterface

FILE: sv/ikh_ctrl.sv
module ikh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ikh_pkg::ikh_stat_t stat,
  output ikh_pkg::ikh_cmd_t  cmd
);
  import ikh_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.clr    = (state == S_CLEAR);
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.hash   = (state == S_HASH);
    cmd.start  = (state == S_ISSUE);
    cmd.probe  = (state == S_PROBE);
    cmd.commit = (state == S_POST) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clr_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_HASH;
      S_HASH:  if (stat.hash_done) state_next = S_ISSUE;
      S_ISSUE: state_next = S_PROBE;
      S_PROBE: if (stat.probe_done) state_next = S_POST;
      S_POST:  if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> (state == S_CLEAR))
    else $error("clearing pass not entered after reset");
  a_load_hashes: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_HASH))
    else $error("accepted item did not start hashing");
  a_done_in_probe: assert property (@(posedge clk) disable iff (rst)
    stat.probe_done |-> (state == S_PROBE))
    else $error("probe finished outside the probe walk");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.commit)
    else $error("result overwritten while stalled");

endmodule

FILE: sv/ikh_dp.sv
module ikh_dp #(
  parameter int SLOT_W = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ikh_pkg::ikh_cmd_t             cmd,
  output ikh_pkg::ikh_stat_t            stat,
  input  logic [ikh_pkg::SIZE_W-1:0]    cfg_size_log2,
  input  logic [ikh_pkg::PLIM_W-1:0]    cfg_probe_limit,
  input  logic                          mode,
  input  logic [ikh_pkg::SEAT_W-1:0]    player_seat,
  input  logic [ikh_pkg::ROUND_W-1:0]   round_number,
  input  logic [ikh_pkg::BUCKET_W-1:0]  strength_bucket,
  input  logic [ikh_pkg::KEY_W-1:0]     board_key,
  input  logic [ikh_pkg::KEY_W-1:0]     history_key,
  input  logic [ikh_pkg::COUNT_W-1:0]   action_count,
  output logic [ikh_pkg::STATUS_W-1:0]  status,
  output logic [SLOT_W-1:0]             slot_index,
  output logic [ikh_pkg::COUNT_W-1:0]   stored_count
);
  import ikh_pkg::*;

  localparam int DEPTH   = 1 << SLOT_W;
  localparam int LOG2_W  = $clog2(SLOT_W + 1);
  localparam int CNT_W   = (SLOT_W + 1 > PLIM_W) ? SLOT_W + 1 : PLIM_W;
  localparam int ENTRY_W = COUNT_W + SMALL_W + 2 * KEY_W;

  // stored entry: {count, small key, history key, board key}
  logic                used_mem [DEPTH];
  logic [ENTRY_W-1:0]  key_mem  [DEPTH];

  logic                mode_q;
  logic [SMALL_W-1:0]  small_q;
  logic [KEY_W-1:0]    board_q;
  logic [KEY_W-1:0]    hist_q;
  logic [COUNT_W-1:0]  count_q;
  logic [SLOT_W-1:0]   mask_q;
  logic [PLIM_W-1:0]   limit_q;
  logic [KEY_W-1:0]    h;
  logic [1:0]          hstep;
  logic [SLOT_W-1:0]   next_addr;
  logic [SLOT_W-1:0]   eval_addr;
  logic [CNT_W-1:0]    n_q;
  logic [SLOT_W-1:0]   clr_addr;
  logic                used_rd;
  logic [ENTRY_W-1:0]  key_rd;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [COUNT_W-1:0]  res_count;

  logic [LOG2_W-1:0]   act_log2;
  logic [KEY_W-1:0]    mix_a, mix_b;
  logic [SLOT_W-1:0]   home;
  logic [SLOT_W-1:0]   rd_addr;
  logic                rd_en;
  logic                key_match;
  logic                stop;
  logic                ins_write;
  logic [STATUS_W-1:0] ev_status;
  logic [SLOT_W-1:0]   ev_slot;
  logic [COUNT_W-1:0]  ev_count;

  // clamp the size register into the supported range
  always_comb begin
    if (cfg_size_log2 < MIN_SIZE_LOG2) act_log2 = LOG2_W'(MIN_SIZE_LOG2);
    else if (32'(cfg_size_log2) > SLOT_W) act_log2 = LOG2_W'(SLOT_W);
    else act_log2 = LOG2_W'(cfg_size_log2);
  end

  always_comb begin
    mix_a = h;
    mix_b = KEY_W'(small_q[SEAT_W-1:0]);
    case (hstep)
      2'd0: begin
        mix_a = board_q;
        mix_b = hist_q;
      end
      2'd1: mix_b = KEY_W'(small_q[SEAT_W-1:0]);
      2'd2: mix_b = KEY_W'(small_q[SEAT_W+ROUND_W-1:SEAT_W]);
      default: mix_b = KEY_W'(small_q[SMALL_W-1:SEAT_W+ROUND_W]);
    endcase
  end

  assign home    = h[SLOT_W-1:0] & mask_q;
  assign rd_addr = cmd.start ? home : next_addr;
  assign rd_en   = cmd.start || cmd.probe;

  assign key_match = (key_rd[ENTRY_W-COUNT_W-1:0] == {small_q, hist_q, board_q});

  always_comb begin
    stop      = 1'b0;
    ins_write = 1'b0;
    ev_status = ST_MISS;
    ev_slot   = '0;
    ev_count  = '0;
    if (cmd.probe) begin
      if (mode_q == MODE_INSERT) begin
        if (n_q > CNT_W'(mask_q)) begin
          stop      = 1'b1;
          ev_status = ST_FULL;
        end else if (!used_rd) begin
          stop      = 1'b1;
          ins_write = 1'b1;
          ev_status = ST_INSERTED;
          ev_slot   = eval_addr;
          ev_count  = count_q;
        end
      end else begin
        if (n_q >= CNT_W'(limit_q) || !used_rd) begin
          stop      = 1'b1;
          ev_status = ST_MISS;
        end else if (key_match) begin
          stop      = 1'b1;
          ev_status = ST_HIT;
          ev_slot   = eval_addr;
          ev_count  = key_rd[ENTRY_W-1:ENTRY_W-COUNT_W];
        end
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.clr_done   = cmd.clr && (clr_addr == {SLOT_W{1'b1}});
    stat.hash_done  = cmd.hash && (hstep == 2'd3);
    stat.probe_done = stop;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      small_q <= {strength_bucket, round_number, player_seat};
      board_q <= board_key;
      hist_q  <= history_key;
      count_q <= (action_count > MAX_ACTION_COUNT) ? MAX_ACTION_COUNT : action_count;
      mask_q  <= ~({SLOT_W{1'b1}} << act_log2);
      limit_q <= cfg_probe_limit;
      hstep   <= 2'd0;
    end
    if (cmd.hash) begin
      h     <= ikh_mix(mix_a, mix_b);
      hstep <= hstep + 2'd1;
    end
    if (cmd.start) begin
      next_addr <= (home + 1'b1) & mask_q;
      n_q       <= '0;
    end
    if (cmd.probe) begin
      next_addr <= (next_addr + 1'b1) & mask_q;
      n_q       <= n_q + 1'b1;
    end
    if (stop) begin
      res_status <= ev_status;
      res_slot   <= ev_slot;
      res_count  <= ev_count;
    end
    if (cmd.commit) begin
      status       <= res_status;
      slot_index   <= res_slot;
      stored_count <= res_count;
    end
  end

  // occupancy map: cleared by a sweep after reset, set by inserts
  always_ff @(posedge clk) begin
    if (cmd.clr) used_mem[clr_addr] <= 1'b0;
    else if (ins_write) used_mem[eval_addr] <= 1'b1;
    if (rd_en) begin
      used_rd   <= used_mem[rd_addr];
      eval_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_write) key_mem[eval_addr] <= {count_q, small_q, hist_q, board_q};
    if (rd_en) key_rd <= key_mem[rd_addr];
  end

endmodule

FILE: sv/info_key_hash_table.sv
// Open-addressing key table with linear probing.
// query channel: one item per request; mode selects insert or lookup. The key is
// seat, round, bucket and two 64-bit hashes; action_count is stored on insert.
// result channel: one item per query: status (inserted, hit, miss, full), the
// slot index for an external payload store and the stored action count.
// APB port: register 0 at 0x0 is table_size_log2, register 1 at 0x4 is probe_limit.
// Write them only while no query is in flight.
// Sequence: hash mixing (one mix unit, one combine per cycle), the issue of the
// home read, the probe walk, one slot read a cycle (a walk ended by the probe
// limit or by a full table reads one slot beyond the last one examined), and the
// load of the output register, which waits while a stalled result is held there.
// One query is worked at a time; the next is taken in the cycle after the result is
// registered at the earliest. The probe walk is set by the single read port of the
// slot memory.
// Reset: registers return to 14 and 1000, and the occupancy map is swept clear,
// one slot a cycle, over all 2^MAX_SLOTS_LOG2 slots (16384 by default) while query
// ready is low.
// A stalled result holds in the output register; the next query is still taken
// and worked, and waits before its result is loaded until the first is taken.
module info_key_hash_table #(
  parameter int MAX_SLOTS_LOG2 = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  ikh_query_if.sink                    query,
  ikh_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ikh_pkg::ADDR_W-1:0]   paddr,
  input  logic [ikh_pkg::DATA_W-1:0]   pwdata,
  output logic [ikh_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import ikh_pkg::*;

  logic [SIZE_W-1:0] table_size_log2;
  logic [PLIM_W-1:0] probe_limit;
  ikh_cmd_t          cmd;
  ikh_stat_t         stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size_log2 <= RST_SIZE_LOG2;
      probe_limit     <= RST_PROBE_LIMIT;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TABLE_SIZE:  table_size_log2 <= pwdata[SIZE_W-1:0];
        REG_PROBE_LIMIT: probe_limit     <= pwdata[PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TABLE_SIZE:  prdata = DATA_W'(table_size_log2);
      REG_PROBE_LIMIT: prdata = DATA_W'(probe_limit);
      default:         prdata = '0;
    endcase
  end

  ikh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ikh_dp #(
    .SLOT_W (MAX_SLOTS_LOG2)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_size_log2   (table_size_log2),
    .cfg_probe_limit (probe_limit),
    .mode            (query.mode),
    .player_seat     (query.player_seat),
    .round_number    (query.round_number),
    .strength_bucket (query.strength_bucket),
    .board_key       (query.board_key),
    .history_key     (query.history_key),
    .action_count    (query.action_count),
    .status          (result.status),
    .slot_index      (result.slot_index),
    .stored_count    (result.stored_count)
  );

endmodule

FILE: dv/info_key_hash_table_tb.sv
module info_key_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ikh_pkg::*;

  localparam int SLOT_W       = 14;
  localparam int DEPTH        = 1 << SLOT_W;
  localparam int FILL_ITEMS   = 16;
  localparam int HOLD_CYCLES  = 500;
  localparam int IDLE_SETTLE  = 4;
  localparam int END_SETTLE   = 40;
  localparam int KNOWN_CAP    = 500;
  localparam int PRINT_CAP    = 30;

  typedef struct packed {
    logic                mode;
    logic [SEAT_W-1:0]   seat;
    logic [ROUND_W-1:0]  round;
    logic [BUCKET_W-1:0] bucket;
    logic [KEY_W-1:0]    board;
    logic [KEY_W-1:0]    hist;
    logic [COUNT_W-1:0]  count;
  } table_query_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  typedef enum logic [1:0] {ROW_QUERY, ROW_CONFIG, ROW_FILL} row_kind_e;
  typedef enum logic [2:0] {DK_A, DK_ONES, DK_ZERO, DK_ZERO_SEAT, DK_FRESH} dir_key_e;

  typedef struct packed {
    row_kind_e           kind;
    logic                mode;
    dir_key_e            key;
    logic [COUNT_W-1:0]  count;
    logic                typed;
    logic [STATUS_W-1:0] want;
    logic [SIZE_W-1:0]   size;
    logic [PLIM_W-1:0]   limit;
  } stim_row_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [PLIM_W-1:0] limit;
    logic [11:0]       items;
  } phase_t;

  localparam table_query_t KEY_A_VAL = '{MODE_INSERT, 3'd3, 2'd2, 8'h5a,
                                         64'h0123_4567_89ab_cdef,
                                         64'hfedc_ba98_7654_3210, 5'd0};

  // kind, mode, key, count, typed, status, size, limit
  stim_row_t directed_rows [26] = '{
    '{ROW_QUERY,  MODE_LOOKUP, DK_A,         5'd0,  1'b1, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_INSERT, DK_A,         5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_LOOKUP, DK_A,         5'd31, 1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_INSERT, DK_A,         5'd31, 1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_LOOKUP, DK_A,         5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_INSERT, DK_ONES,      5'd20, 1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_LOOKUP, DK_ONES,      5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_INSERT, DK_ZERO,      5'd1,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_LOOKUP, DK_ZERO,      5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_LOOKUP, DK_ZERO_SEAT, 5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_INSERT, DK_ONES,      5'd21, 1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_CONFIG, MODE_LOOKUP, DK_A,         5'd0,  1'b0, ST_MISS, 4'd14, 15'd0},
    '{ROW_QUERY,  MODE_LOOKUP, DK_A,         5'd0,  1'b1, ST_MISS, 4'd0,  15'd0},
    '{ROW_CONFIG, MODE_LOOKUP, DK_A,         5'd0,  1'b0, ST_MISS, 4'd0,  15'd40},
    '{ROW_QUERY,  MODE_LOOKUP, DK_ONES,      5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_FILL,   MODE_INSERT, DK_FRESH,     5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_INSERT, DK_FRESH,     5'd5,  1'b1, ST_FULL, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_LOOKUP, DK_FRESH,     5'd0,  1'b1, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_LOOKUP, DK_A,         5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_CONFIG, MODE_LOOKUP, DK_A,         5'd0,  1'b0, ST_MISS, 4'd15, 15'd32767},
    '{ROW_QUERY,  MODE_LOOKUP, DK_ONES,      5'd0,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_QUERY,  MODE_INSERT, DK_FRESH,     5'd7,  1'b0, ST_MISS, 4'd0,  15'd0},
    '{ROW_CONFIG, MODE_LOOKUP, DK_A,         5'd0,  1'b0, ST_MISS, 4'd4,  15'd32767},
    '{ROW_QUERY,  MODE_LOOKUP, DK_FRESH,     5'd0,  1'b1, ST_MISS, 4'd0,  15'd0},
    '{ROW_CONFIG, MODE_LOOKUP, DK_A,         5'd0,  1'b0, ST_MISS, 4'd4,  15'd1},
    '{ROW_QUERY,  MODE_LOOKUP, DK_A,         5'd0,  1'b0, ST_MISS, 4'd0,  15'd0}
  };

  phase_t phases [7] = '{
    '{4'd5,  15'd8,     12'd200},
    '{4'd6,  15'd64,    12'd300},
    '{4'd8,  15'd20,    12'd300},
    '{4'd10, 15'd200,   12'd300},
    '{4'd12, 15'd1,     12'd250},
    '{4'd14, 15'd1000,  12'd300},
    '{4'd15, 15'd16384, 12'd150}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  ikh_query_if                       q_if ();
  ikh_result_if #(.SLOT_W(SLOT_W))   r_if ();

  info_key_hash_table #(.MAX_SLOTS_LOG2(SLOT_W)) u_top (
    .clk     (clk),
    .rst     (rst),
    .query   (q_if),
    .result  (r_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the slot store and the registers
  bit                 shadow_used  [DEPTH];
  logic [KEY_W-1:0]   shadow_board [DEPTH];
  logic [KEY_W-1:0]   shadow_hist  [DEPTH];
  logic [SMALL_W-1:0] shadow_small [DEPTH];
  logic [COUNT_W-1:0] shadow_count [DEPTH];
  logic [SIZE_W-1:0]  size_shadow;
  logic [PLIM_W-1:0]  limit_shadow;

  table_result_t results_due [$];
  table_query_t  known_keys [$];
  int unsigned   mismatches;
  int unsigned   hold_requests;
  int unsigned   holds_done;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic logic [KEY_W-1:0] golden_combine(input logic [KEY_W-1:0] a,
                                                      input logic [KEY_W-1:0] b);
    return a ^ (b + 64'h9e37_79b9_7f4a_7c15 + (a << 6) + (a >> 2));
  endfunction

  // Work out the result of one query and update the shadow store.
  function automatic table_result_t probe_table(input table_query_t q);
    logic [KEY_W-1:0]   h;
    logic [SLOT_W-1:0]  mask;
    logic [SLOT_W-1:0]  idx;
    logic [SMALL_W-1:0] small_key;
    int unsigned        lg;
    int unsigned        n;
    table_result_t      r;
    lg = size_shadow;
    if (lg < MIN_SIZE_LOG2) lg = MIN_SIZE_LOG2;
    if (lg > SLOT_W) lg = SLOT_W;
    mask = SLOT_W'((32'd1 << lg) - 1);
    small_key = {q.bucket, q.round, q.seat};
    h = golden_combine(q.board, q.hist);
    h = golden_combine(h, KEY_W'(q.seat));
    h = golden_combine(h, KEY_W'(q.round));
    h = golden_combine(h, KEY_W'(q.bucket));
    idx = h[SLOT_W-1:0] & mask;
    r = '{ST_MISS, '0, '0};
    if (q.mode == MODE_INSERT) begin
      r.status = ST_FULL;
      for (n = 0; n <= mask; n++) begin
        if (!shadow_used[idx]) begin
          shadow_used[idx]  = 1'b1;
          shadow_board[idx] = q.board;
          shadow_hist[idx]  = q.hist;
          shadow_small[idx] = small_key;
          shadow_count[idx] = (q.count > MAX_ACTION_COUNT) ? MAX_ACTION_COUNT : q.count;
          r = '{ST_INSERTED, idx, shadow_count[idx]};
          break;
        end
        idx = (idx + 1'b1) & mask;
      end
    end else begin
      n = 0;
      while (shadow_used[idx] && n < limit_shadow) begin
        if (shadow_small[idx] == small_key && shadow_board[idx] == q.board &&
            shadow_hist[idx] == q.hist) begin
          r = '{ST_HIT, idx, shadow_count[idx]};
          break;
        end
        idx = (idx + 1'b1) & mask;
        n++;
      end
    end
    return r;
  endfunction

  function automatic table_query_t fresh_key();
    table_query_t k;
    k.mode   = MODE_INSERT;
    k.seat   = SEAT_W'($urandom);
    k.round  = ROUND_W'($urandom);
    k.bucket = BUCKET_W'($urandom);
    k.board  = {$urandom, $urandom};
    k.hist   = {$urandom, $urandom};
    k.count  = '0;
    return k;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // Offer one item; leave valid high on return so a back-to-back item can follow.
  task automatic offer_query(input table_query_t q, input int unsigned gap,
                             input bit typed, input logic [STATUS_W-1:0] typed_status);
    table_result_t want;
    if (gap != 0) begin
      q_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    q_if.valid           <= 1'b1;
    q_if.mode            <= q.mode;
    q_if.player_seat     <= q.seat;
    q_if.round_number    <= q.round;
    q_if.strength_bucket <= q.bucket;
    q_if.board_key       <= q.board;
    q_if.history_key     <= q.hist;
    q_if.action_count    <= q.count;
    do @(posedge clk); while (!q_if.ready);
    want = probe_table(q);
    if (typed) want = '{typed_status, '0, '0};
    results_due.push_back(want);
  endtask

  task automatic drain_results();
    q_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] size, input logic [PLIM_W-1:0] limit);
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b1, {REG_TABLE_SIZE, 2'b00}, DATA_W'(size), rd);
    size_shadow = size;
    apb_xfer(1'b0, {REG_TABLE_SIZE, 2'b00}, '0, rd);
    if (rd !== DATA_W'(size))
      report($sformatf("table_size_log2 reads %0d, wrote %0d", rd, size));
    apb_xfer(1'b1, {REG_PROBE_LIMIT, 2'b00}, DATA_W'(limit), rd);
    limit_shadow = limit;
    apb_xfer(1'b0, {REG_PROBE_LIMIT, 2'b00}, '0, rd);
    if (rd !== DATA_W'(limit))
      report($sformatf("probe_limit reads %0d, wrote %0d", rd, limit));
  endtask

  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && r_if.valid && r_if.ready) begin
      if (results_due.size() == 0) begin
        report($sformatf("result with none due: status %0d slot %0d count %0d",
                         r_if.status, r_if.slot_index, r_if.stored_count));
      end else begin
        want = results_due.pop_front();
        if (r_if.status !== want.status)
          report($sformatf("status %0d, want %0d", r_if.status, want.status));
        if (r_if.slot_index !== want.slot)
          report($sformatf("slot_index %0d, want %0d", r_if.slot_index, want.slot));
        if (r_if.stored_count !== want.count)
          report($sformatf("stored_count %0d, want %0d", r_if.stored_count, want.count));
      end
    end
  end

  // Result side: random stalls, runs of no stalls, and a long hold on request.
  initial begin : result_sink
    int unsigned r;
    r_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        r_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        r = $urandom_range(99);
        if (r < 70) begin
          r_if.ready <= 1'b1;
          repeat ($urandom_range(30, 1)) @(posedge clk);
        end else if (r < 90) begin
          r_if.ready <= 1'b0;
          repeat ($urandom_range(3, 1)) @(posedge clk);
        end else if (r < 97) begin
          r_if.ready <= 1'b0;
          repeat ($urandom_range(50, 10)) @(posedge clk);
        end else begin
          r_if.ready <= 1'b1;
          repeat ($urandom_range(300, 100)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t    row;
    table_query_t q;
    int unsigned  i;
    int unsigned  n;
    int unsigned  p;
    int unsigned  pick;
    bit           new_key;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    q_if.valid           = 1'b0;
    q_if.mode            = MODE_INSERT;
    q_if.player_seat     = '0;
    q_if.round_number    = '0;
    q_if.strength_bucket = '0;
    q_if.board_key       = '0;
    q_if.history_key     = '0;
    q_if.action_count    = '0;
    size_shadow          = RST_SIZE_LOG2;
    limit_shadow         = RST_PROBE_LIMIT;
    mismatches           = 0;
    hold_requests        = 0;
    holds_done           = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_CONFIG: begin
          drain_results();
          set_config(row.size, row.limit);
        end
        ROW_FILL: begin
          for (n = 0; n < FILL_ITEMS; n++) begin
            q = fresh_key();
            q.count = COUNT_W'($urandom_range(31));
            offer_query(q, pick_gap(), 1'b0, ST_MISS);
          end
        end
        default: begin
          case (row.key)
            DK_A:         q = KEY_A_VAL;
            DK_ONES:      q = '1;
            DK_ZERO:      q = '0;
            DK_ZERO_SEAT: begin
              q = '0;
              q.seat = 3'd1;
            end
            default:      q = fresh_key();
          endcase
          q.mode  = row.mode;
          q.count = row.count;
          offer_query(q, pick_gap(), row.typed, row.want);
        end
      endcase
    end

    for (p = 0; p < $size(phases); p++) begin
      drain_results();
      set_config(phases[p].size, phases[p].limit);
      for (i = 0; i < phases[p].items; i++) begin
        // fill the block while results are held back
        if (p == 1 && i == 100) hold_requests++;
        // hold the sender until everything in flight has come back
        if (p == 3 && i == 150) drain_results();
        pick = $urandom_range(99);
        new_key = 1'b0;
        if (pick < 35 || known_keys.size() == 0) begin
          q = fresh_key();
          new_key = 1'b1;
        end else begin
          q = known_keys[$urandom_range(known_keys.size() - 1)];
          if (pick < 45) begin
            q.mode = MODE_INSERT;
          end else begin
            q.mode = MODE_LOOKUP;
            if (pick >= 95) begin
              q = fresh_key();
              q.mode = MODE_LOOKUP;
            end else if (pick >= 92) begin
              q.seat = q.seat ^ SEAT_W'($urandom_range(7, 1));
            end else if (pick >= 88) begin
              q.board[$urandom_range(KEY_W - 1)] = ~q.board[$urandom_range(KEY_W - 1)];
              q.hist[$urandom_range(KEY_W - 1)]  = ~q.hist[$urandom_range(KEY_W - 1)];
            end
          end
        end
        q.count = COUNT_W'($urandom_range(31));
        offer_query(q, ((i % 128) < 32) ? 0 : pick_gap(), 1'b0, ST_MISS);
        if (new_key) begin
          known_keys.push_back(q);
          if (known_keys.size() > KNOWN_CAP) known_keys.delete($urandom_range(KNOWN_CAP - 1));
        end
      end
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("info_key_hash_table_tb OK");
    end else begin
      $display("info_key_hash_table_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("info_key_hash_table_tb NOT OK");
    $finish;
  end

endmodule
